>>> src/dss_pkg.sv
// shared types, constants and calendar helpers for the datetime shift unit
// no dependencies; imported by every module of the block
package dss_pkg;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;

    localparam logic [5:0] DAY_DIV_STEPS  = 6'd3;
    localparam logic [5:0] HOUR_DIV_STEPS = 6'd3;
    localparam logic [5:0] MIN_DIV_STEPS  = 6'd3;

    // x / (2^s * d) as ((x >> s) * ceil(2^k / d)) >> k
    // day: s = 7, d = 675, k = 35; hour: s = 4, d = 225, k = 21; minute: s = 2, d = 15, k = 14
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;
    localparam logic [25:0] RECIP_HOUR = 26'd9321;
    localparam logic [25:0] RECIP_MIN  = 26'd1093;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } div_sel_t;

    // 25 * 3113 == 1 mod 4096; a multiple of 25 maps to at most 4095 / 25
    localparam logic [11:0] INV_25     = 12'd3113;
    localparam logic [11:0] DIV_25_LIM = 12'd163;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;
    localparam logic [4:0] FIRST_DAY = 5'd1;
    localparam logic [4:0] LAST_DAY_DEC = 5'd31;

    localparam logic [0:0] ACT_ADD = 1'b0;

    typedef struct packed {
        logic        action;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [10:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [30:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  res_day;
        logic [3:0]  res_month;
        logic [11:0] res_year;
        logic [4:0]  res_hour;
        logic [5:0]  res_minute;
        logic [5:0]  res_second;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic load_day;
        logic load_hour;
        logic load_min;
        logic div_step;
        logic fix;
        logic walk_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic steps_zero;
    } dp_status_t;

    function automatic logic is_leap(input logic [11:0] y);
        logic [11:0] p;
        logic        div25;
        p     = y * INV_25;
        div25 = (p <= DIV_25_LIM);
        return ((y[3:0] == 4'd0) && div25) || ((y[1:0] == 2'd0) && !div25);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            MONTH_JAN, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, MONTH_DEC: len = 5'd31;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

endpackage

>>> src/dss_div.sv
// divider by 86400, 3600 or 60 through reciprocal multiplication, three steps:
// product, quotient, remainder; depends on dss_pkg
module dss_div (
    input  logic              aclk,
    input  logic              load,
    input  logic              step,
    input  dss_pkg::div_sel_t sel,
    input  logic [31:0]       dividend,
    output logic [15:0]       quo,
    output logic [16:0]       rem
);
    import dss_pkg::*;

    typedef enum logic [1:0] {
        PH_MUL,
        PH_QUO,
        PH_REM
    } phase_t;

    div_sel_t    sel_reg;
    phase_t      phase_reg;
    logic [31:0] x_reg;
    logic [50:0] prod_reg;
    logic [15:0] quo_reg;
    logic [16:0] rem_reg;

    logic [24:0] pre;
    logic [25:0] recip;
    logic [16:0] divisor;
    logic [15:0] quo_next;
    logic [31:0] back;
    logic [31:0] diff;

    always_comb begin
        case (sel_reg)
            DIV_HOUR: begin
                pre      = x_reg[28:4];
                recip    = RECIP_HOUR;
                divisor  = SECS_PER_HOUR;
                quo_next = prod_reg[36:21];
            end
            DIV_MIN: begin
                pre      = x_reg[26:2];
                recip    = RECIP_MIN;
                divisor  = SECS_PER_MIN;
                quo_next = prod_reg[29:14];
            end
            default: begin
                pre      = x_reg[31:7];
                recip    = RECIP_DAY;
                divisor  = SECS_PER_DAY;
                quo_next = prod_reg[50:35];
            end
        endcase
        back = 32'(quo_reg) * 32'(divisor);
        diff = x_reg - back;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sel_reg   <= sel;
            x_reg     <= dividend;
            phase_reg <= PH_MUL;
        end else if (step) begin
            case (phase_reg)
                PH_MUL: begin
                    prod_reg  <= 51'(pre) * 51'(recip);
                    phase_reg <= PH_QUO;
                end
                PH_QUO: begin
                    quo_reg   <= quo_next;
                    phase_reg <= PH_REM;
                end
                default: begin
                    rem_reg   <= diff[16:0];
                end
            endcase
        end
    end

    assign quo = quo_reg;
    assign rem = rem_reg;

endmodule

>>> src/dss_dp.sv
// datapath: input capture, seconds split by 86400/3600/60, calendar walk
// depends on dss_pkg and dss_div
module dss_dp (
    input  logic                aclk,
    input  dss_pkg::dp_cmd_t    cmd,
    input  dss_pkg::in_item_t   in_item,
    output dss_pkg::dp_status_t status,
    output dss_pkg::out_item_t  res
);
    import dss_pkg::*;

    logic        act_reg;
    logic        neg_reg;
    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [11:0] year_reg;
    logic [16:0] tod_reg;
    logic [30:0] amt_reg;
    logic [15:0] steps_reg;
    logic [16:0] rem_reg;
    logic [4:0]  hour_reg;
    out_item_t   res_reg;

    logic [16:0] tod_in;
    logic [31:0] amt_w;
    logic [31:0] tod_w;
    logic        amt_gt;
    logic [31:0] dividend;

    logic        div_load;
    div_sel_t    div_sel;
    logic [31:0] div_x;
    logic [15:0] div_quo;
    logic [16:0] div_rem;

    logic        rem_nz;
    logic [15:0] fix_steps;
    logic [16:0] fix_rem;

    logic        leap;
    logic [4:0]  len_cur;
    logic [4:0]  len_prev;
    logic [4:0]  gap;
    logic [4:0]  take;
    logic [4:0]  day_next;
    logic [3:0]  month_next;
    logic [11:0] year_next;
    logic [15:0] steps_next;

    always_comb begin
        tod_in = 17'(in_item.hour) * SECS_PER_HOUR + 17'(in_item.minute) * SECS_PER_MIN
               + 17'(in_item.second);
        amt_w  = 32'(amt_reg);
        tod_w  = 32'(tod_reg);
        amt_gt = (amt_w > tod_w);
        if (act_reg == ACT_ADD) begin
            dividend = amt_w + tod_w;
        end else if (amt_gt) begin
            dividend = amt_w - tod_w;
        end else begin
            dividend = tod_w - amt_w;
        end
    end

    always_comb begin
        div_load = cmd.load_day | cmd.load_hour | cmd.load_min;
        if (cmd.load_hour) begin
            div_sel = DIV_HOUR;
            div_x   = 32'(rem_reg);
        end else if (cmd.load_min) begin
            div_sel = DIV_MIN;
            div_x   = 32'(div_rem);
        end else begin
            div_sel = DIV_DAY;
            div_x   = dividend;
        end
    end

    dss_div u_div (
        .aclk     (aclk),
        .load     (div_load),
        .step     (cmd.div_step),
        .sel      (div_sel),
        .dividend (div_x),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    // day count and leftover seconds once the 86400 split is done
    always_comb begin
        rem_nz = (div_rem != '0);
        if (act_reg == ACT_ADD) begin
            fix_steps = div_quo;
            fix_rem   = div_rem;
        end else if (neg_reg) begin
            fix_steps = div_quo + 16'(rem_nz);
            fix_rem   = rem_nz ? (SECS_PER_DAY - div_rem) : '0;
        end else begin
            fix_steps = '0;
            fix_rem   = div_rem;
        end
    end

    // one walk step: jump inside the month, or cross one month boundary
    always_comb begin
        leap       = is_leap(year_reg);
        len_cur    = month_len(month_reg, leap);
        len_prev   = month_len(month_reg - 4'd1, leap);
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        steps_next = steps_reg - 16'd1;
        gap        = '0;
        take       = '0;
        if (act_reg == ACT_ADD) begin
            if (day_reg < len_cur) begin
                gap        = len_cur - day_reg;
                take       = (steps_reg < 16'(gap)) ? steps_reg[4:0] : gap;
                day_next   = day_reg + take;
                steps_next = steps_reg - 16'(take);
            end else if (month_reg < MONTH_DEC) begin
                month_next = month_reg + 4'd1;
                day_next   = FIRST_DAY;
            end else begin
                year_next  = year_reg + 12'd1;
                month_next = MONTH_JAN;
                day_next   = FIRST_DAY;
            end
        end else begin
            if (day_reg > FIRST_DAY) begin
                gap        = day_reg - FIRST_DAY;
                take       = (steps_reg < 16'(gap)) ? steps_reg[4:0] : gap;
                day_next   = day_reg - take;
                steps_next = steps_reg - 16'(take);
            end else if (month_reg > MONTH_JAN) begin
                day_next   = len_prev;
                month_next = month_reg - 4'd1;
            end else begin
                year_next  = year_reg - 12'd1;
                month_next = MONTH_DEC;
                day_next   = LAST_DAY_DEC;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg   <= in_item.action;
            day_reg   <= in_item.day;
            month_reg <= in_item.month;
            year_reg  <= 12'(in_item.year);
            tod_reg   <= tod_in;
            amt_reg   <= in_item.amount;
        end else if (cmd.walk_step) begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
        end
        if (cmd.load_day) begin
            neg_reg <= (act_reg != ACT_ADD) && amt_gt;
        end
        if (cmd.fix) begin
            steps_reg <= fix_steps;
            rem_reg   <= fix_rem;
        end else if (cmd.walk_step) begin
            steps_reg <= steps_next;
        end
        if (cmd.load_min) begin
            hour_reg <= div_quo[4:0];
        end
        if (cmd.out_load) begin
            res_reg.res_day    <= day_reg;
            res_reg.res_month  <= month_reg;
            res_reg.res_year   <= year_reg;
            res_reg.res_hour   <= hour_reg;
            res_reg.res_minute <= div_quo[5:0];
            res_reg.res_second <= div_rem[5:0];
        end
    end

    assign status.steps_zero = (steps_reg == '0);
    assign res = res_reg;

endmodule

>>> src/dss_ctrl.sv
// controller: sequences capture, divisions, calendar walk and output handoff
// depends on dss_pkg
module dss_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output dss_pkg::dp_cmd_t    cmd,
    input  dss_pkg::dp_status_t status
);
    import dss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DLOAD,
        S_DDIV,
        S_FIX,
        S_WALK,
        S_HLOAD,
        S_HDIV,
        S_MLOAD,
        S_MDIV,
        S_DONE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [5:0] cnt_reg;
    logic [5:0] cnt_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DLOAD;
                end
            end
            S_DLOAD: begin
                cmd.load_day = 1'b1;
                cnt_next     = DAY_DIV_STEPS;
                state_next   = S_DDIV;
            end
            S_DDIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = S_FIX;
                end
            end
            S_FIX: begin
                cmd.fix    = 1'b1;
                state_next = S_WALK;
            end
            S_WALK: begin
                if (status.steps_zero) begin
                    state_next = S_HLOAD;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_HLOAD: begin
                cmd.load_hour = 1'b1;
                cnt_next      = HOUR_DIV_STEPS;
                state_next    = S_HDIV;
            end
            S_HDIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = S_MLOAD;
                end
            end
            S_MLOAD: begin
                cmd.load_min = 1'b1;
                cnt_next     = MIN_DIV_STEPS;
                state_next   = S_MDIV;
            end
            S_MDIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

>>> src/datetime_shift_by_seconds_unit.sv
// top level of the datetime shift unit: moves a date and time by a count of seconds
// depends on dss_pkg, dss_ctrl, dss_dp (and dss_div below it)
//
// usage:
//   s_ channel takes one item: start date, start time, seconds count and direction
//   (s_tuser = 0 adds, 1 subtracts). m_ channel returns the shifted date and time.
//   one item is in work at a time; s_tready is high only while the unit is idle.
//   after accept the unit runs three reciprocal divisions (by 86400, 3600 and 60),
//   each with a load before it; between the first two come the day-count fix-up,
//   the calendar walk and the end-of-walk check, and the output load comes last.
//   each walk step crosses one month boundary or moves inside a partial month,
//   so a shift takes about two steps per month; a full 31-bit count is about 68 years.
//   the result sits in an output register, so the next item is accepted while it
//   waits for m_tready.
//   a stalled receiver holds the result and, once the next item is done, the unit.
//   synchronous active-low reset returns the unit to idle and drops m_tvalid.
module datetime_shift_by_seconds_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // day, month, year, hour, minute, second, amount, zero pad
    input  logic [dss_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [dss_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // res_day, res_month, res_year, res_hour, res_minute, res_second, zero pad
    output logic [dss_pkg::M_TDATA_W-1:0] m_tdata
);
    import dss_pkg::*;

    in_item_t   in_item;
    out_item_t  res;
    dp_cmd_t    cmd;
    dp_status_t status;

    always_comb begin
        in_item.action = s_tuser[0];
        in_item.day    = s_tdata[4:0];
        in_item.month  = s_tdata[8:5];
        in_item.year   = s_tdata[19:9];
        in_item.hour   = s_tdata[24:20];
        in_item.minute = s_tdata[30:25];
        in_item.second = s_tdata[36:31];
        in_item.amount = s_tdata[67:37];
    end

    dss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    dss_dp u_dp (
        .aclk    (aclk),
        .cmd     (cmd),
        .in_item (in_item),
        .status  (status),
        .res     (res)
    );

    assign m_tdata = {2'b00, res.res_second, res.res_minute, res.res_hour,
                      res.res_year, res.res_month, res.res_day};

endmodule
